>>> hw/rtl/bpcs_pkg.sv
// Shared constants and types for the bipolar pulser capture sequencer.
`timescale 1ns / 1ps

package bpcs_pkg;

   localparam int unsigned SAMPLES = 4096;

   localparam int unsigned PHASE_W   = 16;
   localparam int unsigned TIMEOUT_W = 24;
   localparam int unsigned COUNT_W   = 13;
   localparam int unsigned INDEX_W   = 12;
   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [PHASE_W-1:0]   MIN_PHASE_TICKS = 16'd5;
   localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX     = 24'hFFFFFF;
   localparam logic [COUNT_W-1:0]   SAMPLES_LAST    = COUNT_W'(SAMPLES);

   // Input word layout
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned REQ_USER_W = 4;
   // Result word layout
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned RSP_USER_W = 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NEG_TICKS      = 3'd0,
      CSR_DAMP_TICKS     = 3'd1,
      CSR_POS_TICKS      = 3'd2,
      CSR_POSITIVE_FIRST = 3'd3,
      CSR_TIMEOUT_TICKS  = 3'd4
   } csr_addr_type;

   typedef enum logic [2:0] {
      FUNC_TICK   = 3'd0,
      FUNC_START  = 3'd1,
      FUNC_ABORT  = 3'd2,
      FUNC_ARM    = 3'd3,
      FUNC_DISARM = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_FIRST = 2'd1,
      PHASE_DAMP  = 2'd2,
      PHASE_LAST  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_IDLE   = 2'd0,
      STATUS_ACTIVE = 2'd1,
      STATUS_DONE   = 2'd2,
      STATUS_FAULT  = 2'd3
   } status_type;

endpackage

>>> hw/rtl/bipolar_pulser_capture_sequencer_core.sv
// Top level: bipolar pulser phase sequencer with sample capture and timeout.
`timescale 1ns / 1ps

// One input word is one 8 ns pulser tick: a command in req_tuser and an
// optional ADC sample. Each word yields exactly one result word in the
// next cycle, holding the pin levels after that tick, capture status, the
// captured sample with its index, and the armed state. A new word is taken
// every cycle; the only stall is a result register still waiting on
// rsp_tready. All per-tick work (phase countdown, elapsed count, command
// and sample handling) sits between the sequencer state registers and the
// result register. A start while idle opens a capture of SAMPLES samples
// and, if armed, a first-polarity / damp / opposite-polarity pulse whose
// phase lengths are latched as each phase begins. Phase length writes below
// 5 ticks are ignored. Configuration must be written only while idle (unenforced).
module bipolar_pulser_capture_sequencer_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [bpcs_pkg::REQ_DATA_W-1:0]        req_tdata,  // [15:0] sample_value
   input  logic [bpcs_pkg::REQ_USER_W-1:0]        req_tuser,  // [2:0] func, [3] sample_valid
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [0] drive_positive, [1] drive_negative, [2] output_enable, [3] damp_enable,
   // [5:4] capture_status, [6] start_refused, [18:7] sample_index,
   // [34:19] sample_data, [35] armed_flag, [39:36] zero
   output logic [bpcs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [bpcs_pkg::RSP_USER_W-1:0]        rsp_tuser,  // [0] sample_write
   input  logic                                   csr_we,
   input  logic [bpcs_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [bpcs_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import bpcs_pkg::*;

   // Configuration registers
   logic [PHASE_W-1:0]   neg_ticks_ff, damp_len_ff, pos_ticks_ff;
   logic                 positive_first_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   // Sequencer state
   logic                 capturing_ff, capturing_in;
   logic                 armed_ff, armed_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [TIMEOUT_W-1:0] elapsed_ff, elapsed_in;
   phase_type            phase_ff, phase_in;
   logic [PHASE_W-1:0]   remain_ff, remain_in;

   // Result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic                 accept;
   func_type             func;
   logic                 sample_valid;
   logic [SAMPLE_W-1:0]  sample_value;
   logic [PHASE_W-1:0]   csr_ticks;
   logic                 csr_ticks_ok;

   // Per-tick combinational results
   status_type           status;
   logic                 refused, wr;
   logic [INDEX_W-1:0]   idx;
   logic [SAMPLE_W-1:0]  data;
   logic                 dp, dn, oe, de;
   logic [PHASE_W-1:0]   remain_dec;

   function automatic logic [PHASE_W-1:0] phase_len(
      input phase_type            ph,
      input logic                 pos_first,
      input logic [PHASE_W-1:0]   neg_t,
      input logic [PHASE_W-1:0]   damp_t,
      input logic [PHASE_W-1:0]   pos_t
   );
      logic [PHASE_W-1:0] len;
      case (ph)
         PHASE_DAMP:  len = damp_t;
         PHASE_FIRST: len = pos_first ? pos_t : neg_t;
         PHASE_LAST:  len = pos_first ? neg_t : pos_t;
         default:     len = '0;
      endcase
      return len;
   endfunction

   assign accept       = req_tvalid && req_tready;
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign func         = func_type'(req_tuser[2:0]);
   assign sample_valid = req_tuser[3];
   assign sample_value = req_tdata[SAMPLE_W-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign csr_ticks    = csr_wdata[PHASE_W-1:0];
   assign csr_ticks_ok = csr_ticks >= MIN_PHASE_TICKS;

   always_comb begin
      phase_in     = phase_ff;
      remain_in    = remain_ff;
      capturing_in = capturing_ff;
      armed_in     = armed_ff;
      count_in     = count_ff;
      elapsed_in   = elapsed_ff;
      status       = STATUS_IDLE;
      refused      = 1'b0;
      wr           = 1'b0;
      idx          = '0;
      data         = '0;
      remain_dec   = (remain_ff != '0) ? remain_ff - PHASE_W'(1) : '0;

      // pulse advances one tick
      if (phase_ff != PHASE_IDLE) begin
         remain_in = remain_dec;
         if (remain_dec == '0) begin
            if (phase_ff == PHASE_LAST) begin
               phase_in  = PHASE_IDLE;
               remain_in = '0;
            end else begin
               phase_in  = phase_type'(phase_ff + 2'd1);
               remain_in = phase_len(phase_type'(phase_ff + 2'd1), positive_first_ff,
                                     neg_ticks_ff, damp_len_ff, pos_ticks_ff);
            end
         end
      end

      if (capturing_ff && elapsed_ff != ELAPSED_MAX)
         elapsed_in = elapsed_ff + TIMEOUT_W'(1);

      case (func)
         FUNC_START: begin
            if (capturing_ff) begin
               refused = 1'b1;
            end else begin
               capturing_in = 1'b1;
               count_in     = '0;
               elapsed_in   = '0;
               if (armed_ff) begin
                  phase_in  = PHASE_FIRST;
                  remain_in = phase_len(PHASE_FIRST, positive_first_ff,
                                        neg_ticks_ff, damp_len_ff, pos_ticks_ff);
               end else begin
                  phase_in  = PHASE_IDLE;
                  remain_in = '0;
               end
            end
         end
         FUNC_ABORT: begin
            capturing_in = 1'b0;
            armed_in     = 1'b0;
            phase_in     = PHASE_IDLE;
            remain_in    = '0;
         end
         FUNC_ARM: armed_in = 1'b1;
         FUNC_DISARM: begin
            armed_in  = 1'b0;
            phase_in  = PHASE_IDLE;
            remain_in = '0;
         end
         default: ;
      endcase

      // a start resets the counter, so take it from count_in
      if (capturing_in && sample_valid) begin
         wr       = 1'b1;
         idx      = count_in[INDEX_W-1:0];
         data     = sample_value;
         count_in = count_in + COUNT_W'(1);
         if (count_in >= SAMPLES_LAST) begin
            capturing_in = 1'b0;
            status       = STATUS_DONE;
         end
      end

      if (capturing_in && elapsed_in > timeout_ff) begin
         capturing_in = 1'b0;
         armed_in     = 1'b0;
         phase_in     = PHASE_IDLE;
         remain_in    = '0;
         status       = STATUS_FAULT;
      end

      if (capturing_in)
         status = STATUS_ACTIVE;

      dp = 1'b0;
      dn = 1'b0;
      oe = 1'b0;
      de = 1'b0;
      case (phase_in)
         PHASE_FIRST: begin
            oe = 1'b1;
            dn = !positive_first_ff;
            dp = positive_first_ff;
         end
         PHASE_DAMP: begin
            oe = 1'b1;
            de = 1'b1;
         end
         PHASE_LAST: begin
            oe = 1'b1;
            dp = !positive_first_ff;
            dn = positive_first_ff;
         end
         default: ;
      endcase

      rsp_data_in = {4'b0000, armed_in, data, idx, refused, status, de, oe, dn, dp};
      rsp_user_in = wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ticks_ff      <= 16'd12;
         damp_len_ff       <= 16'd750;
         pos_ticks_ff      <= 16'd12;
         positive_first_ff <= 1'b0;
         timeout_ff        <= 24'd250000;
      end else if (csr_we) begin
         case (csr_addr_type'(csr_addr))
            CSR_NEG_TICKS:      if (csr_ticks_ok) neg_ticks_ff <= csr_ticks;
            CSR_DAMP_TICKS:     if (csr_ticks_ok) damp_len_ff <= csr_ticks;
            CSR_POS_TICKS:      if (csr_ticks_ok) pos_ticks_ff <= csr_ticks;
            CSR_POSITIVE_FIRST: positive_first_ff <= csr_wdata[0];
            CSR_TIMEOUT_TICKS:  timeout_ff <= csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capturing_ff <= 1'b0;
         armed_ff     <= 1'b0;
         count_ff     <= '0;
         elapsed_ff   <= '0;
         phase_ff     <= PHASE_IDLE;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            capturing_ff <= capturing_in;
            armed_ff     <= armed_in;
            count_ff     <= count_in;
            elapsed_ff   <= elapsed_in;
            phase_ff     <= phase_in;
            remain_ff    <= remain_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

endmodule

>>> tb/bipolar_pulser_capture_sequencer_core_tb.sv
// Self-checking testbench for the bipolar pulser capture sequencer core.
`timescale 1ns / 1ps

module bipolar_pulser_capture_sequencer_core_tb;
   import bpcs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 4;
   // func codes the block treats as a plain tick
   localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

   // rsp_tuser on top of rsp_tdata, lowest field last
   typedef struct packed {
      logic                written;
      logic [3:0]          pad;
      logic                armed;
      logic [SAMPLE_W-1:0] data;
      logic [INDEX_W-1:0]  index;
      logic                refused;
      logic [1:0]          status;
      logic                damp;
      logic                oe;
      logic                neg;
      logic                pos;
   } tick_result_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor copy of registers and sequencer state
   logic [PHASE_W-1:0]   neg_ticks   = 16'd12;
   logic [PHASE_W-1:0]   damp_len    = 16'd750;
   logic [PHASE_W-1:0]   pos_ticks   = 16'd12;
   logic                 pos_first   = 1'b0;
   logic [TIMEOUT_W-1:0] fault_limit = 24'd250000;
   logic                 cap_open    = 1'b0;
   logic                 armed_now   = 1'b0;
   logic [COUNT_W-1:0]   samples_taken = '0;
   logic [TIMEOUT_W-1:0] ticks_elapsed = '0;
   phase_type            phase_now   = PHASE_IDLE;
   logic [PHASE_W-1:0]   phase_left  = '0;

   tick_result_type tick_results_due[$];
   int unsigned errors = 0;
   int unsigned words_sent = 0;
   int unsigned n_samples = 0, n_done = 0, n_faults = 0, n_refused = 0, n_pulses = 0;
   bit calm = 0;        // no idling on either side
   bit stall_rsp = 0;   // receiver holds off for a long stretch

   bipolar_pulser_capture_sequencer_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic void enter_phase(phase_type ph);
      phase_now = ph;
      case (ph)
         PHASE_FIRST: phase_left = pos_first ? pos_ticks : neg_ticks;
         PHASE_DAMP:  phase_left = damp_len;
         PHASE_LAST:  phase_left = pos_first ? neg_ticks : pos_ticks;
         default:     phase_left = '0;
      endcase
   endfunction

   function automatic void step_pulser(logic [2:0] fn, logic sv, logic [15:0] val);
      tick_result_type r;
      r = '0;
      if (phase_now != PHASE_IDLE) begin
         if (phase_left != 0) phase_left--;
         if (phase_left == 0) begin
            if (phase_now == PHASE_LAST) enter_phase(PHASE_IDLE);
            else enter_phase(phase_type'(phase_now + 2'd1));
         end
      end
      if (cap_open && ticks_elapsed != ELAPSED_MAX) ticks_elapsed++;

      case (fn)
         FUNC_START: begin
            if (cap_open) begin
               r.refused = 1'b1;
               n_refused++;
            end else begin
               cap_open = 1'b1;
               samples_taken = '0;
               ticks_elapsed = '0;
               enter_phase(PHASE_IDLE);
               if (armed_now) begin
                  enter_phase(PHASE_FIRST);
                  n_pulses++;
               end
            end
         end
         FUNC_ABORT: begin
            cap_open = 1'b0;
            armed_now = 1'b0;
            enter_phase(PHASE_IDLE);
         end
         FUNC_ARM: armed_now = 1'b1;
         FUNC_DISARM: begin
            armed_now = 1'b0;
            enter_phase(PHASE_IDLE);
         end
         default: ;
      endcase

      if (cap_open && sv) begin
         r.written = 1'b1;
         r.index = samples_taken[INDEX_W-1:0];
         r.data = val;
         samples_taken++;
         n_samples++;
         if (samples_taken >= SAMPLES_LAST) begin
            cap_open = 1'b0;
            r.status = STATUS_DONE;
            n_done++;
         end
      end

      if (cap_open && ticks_elapsed > fault_limit) begin
         cap_open = 1'b0;
         armed_now = 1'b0;
         enter_phase(PHASE_IDLE);
         r.status = STATUS_FAULT;
         n_faults++;
      end
      if (cap_open) r.status = STATUS_ACTIVE;

      case (phase_now)
         PHASE_FIRST: begin
            r.oe = 1'b1;
            r.neg = ~pos_first;
            r.pos = pos_first;
         end
         PHASE_DAMP: begin
            r.oe = 1'b1;
            r.damp = 1'b1;
         end
         PHASE_LAST: begin
            r.oe = 1'b1;
            r.pos = ~pos_first;
            r.neg = pos_first;
         end
         default: ;
      endcase
      r.armed = armed_now;
      tick_results_due.push_back(r);
   endfunction

   // ---------------------------------------------------------------- checking
   function automatic void compare_field(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      end
   endfunction

   always @(posedge clock) begin
      tick_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[0], rsp_tdata};
         if (tick_results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, actual %h", $time, got);
         end else begin
            want = tick_results_due.pop_front();
            compare_field("drive_positive", want.pos, got.pos);
            compare_field("drive_negative", want.neg, got.neg);
            compare_field("output_enable", want.oe, got.oe);
            compare_field("damp_enable", want.damp, got.damp);
            compare_field("capture_status", want.status, got.status);
            compare_field("start_refused", want.refused, got.refused);
            compare_field("sample_write", want.written, got.written);
            compare_field("sample_index", want.index, got.index);
            compare_field("sample_data", want.data, got.data);
            compare_field("armed_flag", want.armed, got.armed);
            compare_field("tdata pad", want.pad, got.pad);
         end
      end
   end

   // receiver: random backpressure, or a long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_rsp) begin
            rsp_tready <= 1'b0;
            repeat (60) @(posedge clock);
            stall_rsp = 0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 18);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("bipolar_pulser_capture_sequencer_core regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- drivers
   task automatic send_word(input logic [2:0] fn, input logic sv, input logic [15:0] val);
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= {sv, fn};
      req_tdata <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      step_pulser(fn, sv, val);
      words_sent++;
   endtask

   // wait until every result word is back and the block has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_addr_type a, input logic [CSR_DATA_W-1:0] v);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (a)
         CSR_NEG_TICKS:      if (v[15:0] >= MIN_PHASE_TICKS) neg_ticks = v[15:0];
         CSR_DAMP_TICKS:     if (v[15:0] >= MIN_PHASE_TICKS) damp_len = v[15:0];
         CSR_POS_TICKS:      if (v[15:0] >= MIN_PHASE_TICKS) pos_ticks = v[15:0];
         CSR_POSITIVE_FIRST: pos_first = v[0];
         CSR_TIMEOUT_TICKS:  fault_limit = v;
         default: ;
      endcase
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   // ---------------------------------------------------------------- tests
   task automatic test_idle_commands();
      send_word(FUNC_TICK, 1'b1, 16'hFFFF);      // sample with no capture: dropped
      for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
         send_word(3'(f), 1'b0, 16'h0000);
      send_word(FUNC_ABORT, 1'b0, 16'h0000);     // abort while idle only disarms
      send_word(FUNC_DISARM, 1'b1, 16'h5A5A);
      settle();
   endtask

   task automatic test_pulse_and_abort();
      send_word(FUNC_ARM, 1'b0, 16'h0000);
      send_word(FUNC_START, 1'b1, 16'h0000);     // start tick carries sample 0
      send_word(FUNC_TICK, 1'b1, 16'hFFFF);
      send_word(FUNC_START, 1'b1, 16'h1234);     // refused, sample still taken
      send_word(FUNC_SPARE_LAST, 1'b0, 16'h0000);
      send_word(FUNC_DISARM, 1'b1, 16'h8001);    // pins drop, capture goes on
      send_word(FUNC_ARM, 1'b0, 16'h0000);       // no pulse until next start
      send_word(FUNC_TICK, 1'b0, 16'h0000);
      send_word(FUNC_ABORT, 1'b1, 16'hBEEF);     // sample on abort is dropped
      send_word(FUNC_START, 1'b1, 16'h7FFF);     // unarmed: capture, no pulse
      send_word(FUNC_TICK, 1'b1, 16'h0001);
      send_word(FUNC_ABORT, 1'b0, 16'h0000);
      settle();
   endtask

   task automatic test_register_writes();
      write_reg(CSR_NEG_TICKS, 24'd4);           // below minimum: ignored
      write_reg(CSR_DAMP_TICKS, 24'd0);
      write_reg(CSR_POS_TICKS, 24'hFF0003);      // low half below minimum
      write_reg(CSR_POS_TICKS, 24'h010005);
      write_reg(CSR_TIMEOUT_TICKS, 24'd0);       // faults on second tick
      send_word(FUNC_ARM, 1'b0, 16'h0000);
      send_word(FUNC_START, 1'b1, 16'h0F0F);
      send_word(FUNC_TICK, 1'b1, 16'hF0F0);
      send_word(FUNC_TICK, 1'b0, 16'h0000);
      settle();
      write_reg(CSR_TIMEOUT_TICKS, 24'd1);
      send_word(FUNC_ARM, 1'b0, 16'h0000);
      repeat (4) send_word(FUNC_START, 1'b1, pick_sample());
      settle();
   endtask

   task automatic test_phase_change_mid_pulse();
      write_reg(CSR_TIMEOUT_TICKS, 24'd100000);
      write_reg(CSR_NEG_TICKS, 24'd5);
      write_reg(CSR_DAMP_TICKS, 24'd20);
      write_reg(CSR_POS_TICKS, 24'd5);
      write_reg(CSR_POSITIVE_FIRST, 24'd0);
      send_word(FUNC_ARM, 1'b0, 16'h0000);
      send_word(FUNC_START, 1'b0, 16'h0000);
      repeat (3) send_word(FUNC_TICK, 1'b1, pick_sample());
      settle();
      // running phase keeps its length, later phases pick up the new ones
      write_reg(CSR_NEG_TICKS, 24'd30);
      write_reg(CSR_POS_TICKS, 24'd9);
      write_reg(CSR_POSITIVE_FIRST, 24'hFFFFFF);
      repeat (50) send_word(FUNC_TICK, 1'($urandom_range(1)), pick_sample());
      send_word(FUNC_ABORT, 1'b0, 16'h0000);
      settle();
   endtask

   // full capture with the pulse still in its damp phase when done arrives
   task automatic test_full_capture();
      write_reg(CSR_TIMEOUT_TICKS, 24'hFFFFFF);
      write_reg(CSR_NEG_TICKS, 24'd12);
      write_reg(CSR_DAMP_TICKS, 24'd4100);
      write_reg(CSR_POS_TICKS, 24'd12);
      write_reg(CSR_POSITIVE_FIRST, 24'd1);
      send_word(FUNC_ARM, 1'b0, 16'h0000);
      send_word(FUNC_START, 1'b1, pick_sample());
      for (int i = 1; i < SAMPLES; i++)
         send_word((i == 2000) ? FUNC_START : FUNC_TICK, 1'b1, pick_sample());
      repeat (40) send_word(FUNC_TICK, 1'($urandom_range(1)), pick_sample());
      settle();
   endtask

   // full-scale damp length loaded after a short first phase
   task automatic test_longest_phases();
      write_reg(CSR_NEG_TICKS, 24'hFFFFFF);
      write_reg(CSR_DAMP_TICKS, 24'd65535);
      write_reg(CSR_POS_TICKS, 24'd5);
      write_reg(CSR_POSITIVE_FIRST, 24'd1);
      write_reg(CSR_TIMEOUT_TICKS, 24'hFFFFFF);
      send_word(FUNC_ARM, 1'b0, 16'h0000);
      send_word(FUNC_START, 1'b0, 16'h0000);
      repeat (40) send_word(FUNC_TICK, $urandom_range(99) < 2, pick_sample());
      send_word(FUNC_DISARM, 1'b0, 16'h0000);   // cut the damp phase short
      send_word(FUNC_TICK, 1'b0, 16'h0000);
      send_word(FUNC_ABORT, 1'b0, 16'h0000);
      settle();
   endtask

   task automatic random_config();
      logic [7:0] hi;
      hi = 8'($urandom_range(255));
      write_reg(CSR_NEG_TICKS, {hi, ($urandom_range(99) < 10) ?
                16'($urandom_range(4)) : 16'($urandom_range(5, 30))});
      write_reg(CSR_DAMP_TICKS, {~hi, ($urandom_range(99) < 10) ?
                16'($urandom_range(4)) : 16'($urandom_range(5, 60))});
      write_reg(CSR_POS_TICKS, {hi, 16'($urandom_range(5, 30))});
      write_reg(CSR_POSITIVE_FIRST, 24'($urandom()));
      case ($urandom_range(9))
         0, 1: write_reg(CSR_TIMEOUT_TICKS, 24'hFFFFFF);
         2:    write_reg(CSR_TIMEOUT_TICKS, 24'($urandom_range(3)));
         default: write_reg(CSR_TIMEOUT_TICKS, 24'($urandom_range(20, 200)));
      endcase
   endtask

   // mostly arm / start / a run of ticks, sometimes plain noise
   task automatic random_burst();
      logic [2:0] fn;
      if ($urandom_range(99) < 85) begin
         if ($urandom_range(99) < 80)
            send_word(FUNC_ARM, 1'($urandom_range(1)), pick_sample());
         send_word(FUNC_START, 1'($urandom_range(1)), pick_sample());
         repeat ($urandom_range(10, 80)) begin
            fn = FUNC_TICK;
            if ($urandom_range(99) < 10) fn = 3'($urandom_range(1, 7));
            send_word(fn, $urandom_range(99) < 60, pick_sample());
         end
      end else begin
         repeat ($urandom_range(1, 10))
            send_word(3'($urandom_range(7)), 1'($urandom_range(1)), pick_sample());
      end
   endtask

   task automatic test_random_traffic();
      int unsigned stop_at;
      for (int round = 0; round < 6; round++) begin
         random_config();
         calm = (round == 1);
         stop_at = words_sent + 150;
         while (words_sent < stop_at) begin
            if (round == 2 && words_sent + 75 >= stop_at && !stall_rsp) begin
               stall_rsp = 1;
               repeat (20) send_word(FUNC_TICK, 1'b1, pick_sample());
            end
            if (round == 3 && words_sent + 75 >= stop_at && words_sent + 70 < stop_at)
               settle();
            random_burst();
         end
         calm = 0;
         settle();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_we <= 1'b0;
      csr_addr <= CSR_NEG_TICKS;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_idle_commands();
      test_pulse_and_abort();
      test_register_writes();
      test_phase_change_mid_pulse();
      test_full_capture();
      test_longest_phases();
      test_random_traffic();

      $display("covered %0d tick words, %0d pulses fired, %0d samples captured",
               words_sent, n_pulses, n_samples);
      $display("captures done %0d, timeout faults %0d, starts refused %0d",
               n_done, n_faults, n_refused);
      if (errors == 0) begin
         $display("bipolar_pulser_capture_sequencer_core regression: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("bipolar_pulser_capture_sequencer_core regression: fail");
      end
      $finish;
   end

endmodule
